@@ hdl/lri_pkg.sv @@
package lri_pkg;

  // Fixed field widths of the scorer.
  localparam int VALUE_W = 16;
  localparam int ACC_W   = 40;
  localparam int FC_W    = 7;

  // Feature count after reset.
  localparam logic [FC_W-1:0] FC_RESET = 7'd64;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_BIAS    = 2'd1,
    OP_FEATURE = 2'd2,
    OP_SPARE   = 2'd3
  } lri_op_t;

  // Tag carried next to a word in the first pipeline stage.
  typedef struct packed {
    logic                      feat;
    logic                      last;
    logic                      inrange;
    logic                      err;
    logic signed [VALUE_W-1:0] bias;
  } lri_tag_t;

  // Tag carried next to a finished sum toward the output.
  typedef struct packed {
    logic                      res;
    logic                      err;
    logic signed [VALUE_W-1:0] bias;
  } lri_res_t;

  // Signed add into the accumulator range, saturating at both ends.
  function automatic logic signed [ACC_W-1:0] sat_add40(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W:0]   b
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + b;
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add40 = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add40 = s[ACC_W-1:0];
    end
  endfunction

endpackage

@@ hdl/lri_front.sv @@
module lri_front
  import lri_pkg::*;
#(
  parameter int MAX_FEATURES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      accept,
  input  logic [1:0]                in_op,
  input  logic [5:0]                in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  input  logic                      cfg_wr_en,
  input  logic [FC_W-1:0]           cfg_wr_data,
  output lri_tag_t                  a_tag,
  output logic signed [VALUE_W-1:0] a_value,
  output logic signed [VALUE_W-1:0] a_weight
);

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  logic signed [VALUE_W-1:0] wmem [MAX_FEATURES];
  logic signed [VALUE_W-1:0] rdata_r;
  logic signed [VALUE_W-1:0] bias_r, bias_nxt;
  logic signed [VALUE_W-1:0] value_r;
  logic [FC_W-1:0]           fc_r, fc_nxt;
  logic [FC_W-1:0]           seen_r, seen_nxt;
  lri_tag_t                  tag_r, tag_nxt;
  logic [AW-1:0]             addr;
  logic                      inrange;
  logic                      is_feat;
  logic                      err;

  assign addr    = AW'(in_index);
  assign inrange = (32'(in_index) < MAX_FEATURES);
  assign is_feat = accept && (in_op == OP_FEATURE);
  assign err     = ((8'(seen_r) + 8'd1) != 8'(fc_r));

  // Weight memory: written by a weight word, read by a feature word.
  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_WEIGHT) && inrange) begin
      wmem[addr] <= in_value;
    end
    if (accept) begin
      rdata_r <= wmem[addr];
    end
  end

  // Bias, feature count and the per-sample feature counter.
  always_comb begin
    bias_nxt = bias_r;
    fc_nxt   = fc_r;
    seen_nxt = seen_r;
    if (accept && (in_op == OP_BIAS)) begin
      bias_nxt = in_value;
    end
    if (cfg_wr_en) begin
      fc_nxt = cfg_wr_data;
    end
    if (is_feat) begin
      if (in_last) begin
        seen_nxt = '0;
      end else if (seen_r != '1) begin
        seen_nxt = seen_r + 1'b1;
      end
    end
  end

  // Tag for the first stage; the bias is captured with the last feature.
  always_comb begin
    tag_nxt         = '0;
    tag_nxt.feat    = is_feat;
    tag_nxt.last    = in_last;
    tag_nxt.inrange = inrange;
    tag_nxt.err     = err;
    tag_nxt.bias    = bias_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
      fc_r   <= FC_RESET;
      seen_r <= '0;
      tag_r  <= '0;
    end else begin
      bias_r <= bias_nxt;
      fc_r   <= fc_nxt;
      seen_r <= seen_nxt;
      if (adv) begin
        tag_r <= tag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_value;
    end
  end

  assign a_tag    = tag_r;
  assign a_value  = value_r;
  assign a_weight = rdata_r;

endmodule

@@ hdl/lri_mac.sv @@
module lri_mac
  import lri_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  lri_tag_t                  a_tag,
  input  logic signed [VALUE_W-1:0] a_value,
  input  logic signed [VALUE_W-1:0] a_weight,
  output lri_res_t                  c_res,
  output logic signed [ACC_W-1:0]   c_sum
);

  logic signed [2*VALUE_W-1:0] mul;
  logic signed [2*VALUE_W-1:0] prod_r;
  lri_tag_t                    b_tag_r;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [ACC_W-1:0]     sum_r, sum_nxt;
  logic signed [ACC_W-1:0]     s;
  lri_res_t                    res_r, res_nxt;

  // Product of feature and weight; a slot past the memory adds nothing.
  assign mul = a_value * a_weight;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= a_tag.inrange ? mul : '0;
    end
  end

  // Accumulate; the last feature hands the sum on and clears the accumulator.
  assign s = sat_add40(acc_r, (ACC_W+1)'(prod_r));

  always_comb begin
    acc_nxt = acc_r;
    sum_nxt = sum_r;
    res_nxt = '0;
    if (b_tag_r.feat) begin
      if (b_tag_r.last) begin
        sum_nxt     = s;
        acc_nxt     = '0;
        res_nxt.res = 1'b1;
        res_nxt.err = b_tag_r.err;
        res_nxt.bias = b_tag_r.bias;
      end else begin
        acc_nxt = s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tag_r <= '0;
      acc_r   <= '0;
      res_r   <= '0;
    end else if (adv) begin
      b_tag_r <= a_tag;
      acc_r   <= acc_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  assign c_res = res_r;
  assign c_sum = sum_r;

endmodule

@@ hdl/lri_post.sv @@
module lri_post
  import lri_pkg::*;
#(
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  lri_res_t                c_res,
  input  logic signed [ACC_W-1:0] c_sum,
  input  logic                    out_ready,
  output logic                    hold,
  output logic                    out_valid,
  output logic [15:0]             out_probability,
  output logic signed [ACC_W-1:0] out_logit,
  output logic                    out_size_error
);

  localparam int TW = $clog2(SIGMOID_ENTRIES);
  localparam int NW = $clog2(SIGMOID_ENTRIES + 1);
  localparam int PW = 28 + NW;

  // Unsigned divide by shift and subtract, used only while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-a) in Q0.32 for a Q8.24 magnitude: series for a/16, then squared four times.
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
    logic [63:0]        term;
    logic signed [64:0] sum;
    logic [63:0]        e;
    term = 64'd1 << 32;
    sum  = 65'sd1 <<< 32;
    for (int i = 1; i <= 12; i++) begin
      term = udiv64((term * a) >> 28, 64'(i));
      if (i % 2 == 1) begin
        sum = sum - $signed({1'b0, term});
      end else begin
        sum = sum + $signed({1'b0, term});
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    e = sum[63:0];
    for (int i = 0; i < 4; i++) begin
      if (e >= (64'd1 << 32)) begin
        e = 64'd1 << 32;
      end else begin
        e = (e * e) >> 32;
      end
    end
    return e;
  endfunction

  // One sigmoid entry at the midpoint of bin k out of n.
  function automatic logic [15:0] sig_entry(input int k, input int n);
    logic [63:0] off;
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] r;
    logic        neg;
    off = udiv64(64'(2 * k + 1) << 27, 64'(n));
    neg = off < (64'd1 << 27);
    mag = neg ? ((64'd1 << 27) - off) : (off - (64'd1 << 27));
    e   = exp_neg_q32(mag);
    d   = (64'd1 << 32) + e;
    num = neg ? (e << 16) : (64'd1 << 48);
    r   = udiv64(num + (d >> 1), d);
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  logic [15:0] sig_tbl [SIGMOID_ENTRIES];

  for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_tbl
    localparam logic [15:0] ENT = sig_entry(k, SIGMOID_ENTRIES);
    assign sig_tbl[k] = ENT;
  end

  lri_res_t                d_res_r, e_res_r;
  logic signed [ACC_W-1:0] d_logit_r, e_logit_r;
  logic [TW-1:0]           e_idx_r;
  logic signed [ACC_W:0]   bias_ext;
  logic [27:0]             u;
  logic [PW-1:0]           scaled;
  logic                    load;
  logic                    ov_r, ov_nxt;
  logic [15:0]             prob_r;
  logic signed [ACC_W-1:0] logit_r;
  logic                    err_r;

  // Add the bias, moved from Q4.12 to the Q16.24 scale of the sum.
  assign bias_ext = {{(ACC_W + 1 - VALUE_W - 12){d_res_r.bias[VALUE_W-1]}},
                     d_res_r.bias, 12'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      d_logit_r <= c_sum;
      e_logit_r <= sat_add40(d_logit_r, bias_ext);
      e_idx_r   <= scaled[28 +: TW];
    end
  end

  // Clamp the logit to [-8,8) and scale the offset to a table index.
  always_comb begin
    if ((e_logit_r[ACC_W-1:27] == '0) || (e_logit_r[ACC_W-1:27] == '1)) begin
      u = {~e_logit_r[27], e_logit_r[26:0]};
    end else if (e_logit_r[ACC_W-1]) begin
      u = '0;
    end else begin
      u = '1;
    end
  end

  assign scaled = PW'(u) * PW'(SIGMOID_ENTRIES);

  // Index stage, registered from the logit stage under the same advance.
  lri_res_t f_res_r;
  logic signed [ACC_W-1:0] f_logit_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_logit_r <= e_logit_r;
    end
  end

  // The whole pipe holds only when a result waits on a full output register.
  assign hold = f_res_r.res && ov_r && !out_ready;
  assign load = f_res_r.res && !hold;

  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_res_r <= '0;
      e_res_r <= '0;
      f_res_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (adv) begin
        d_res_r <= c_res;
        e_res_r <= d_res_r;
        f_res_r <= e_res_r;
      end
    end
  end

  // Output register: table lookup, logit and size flag.
  always_ff @(posedge clk) begin
    if (load) begin
      prob_r  <= sig_tbl[e_idx_r];
      logit_r <= f_logit_r;
      err_r   <= f_res_r.err;
    end
  end

  assign out_valid       = ov_r;
  assign out_probability = prob_r;
  assign out_logit       = logit_r;
  assign out_size_error  = err_r;

endmodule

@@ hdl/logistic_regression_inference.sv @@
// Channel  | Handshake           | Word
// ---------+---------------------+-------------------------------------------
// in       | in_valid/in_ready   | in_op, in_index, in_value, in_last
// out      | out_valid/out_ready | out_probability, out_logit, out_size_error
// cfg      | cfg_wr_en           | cfg_wr_data (feature count)
//
// One word is taken every cycle while in_ready is high; the multiply-accumulate
// stage closes a sample in one pass and feeds the bias, index and lookup stages.
// Reset (synchronous, active low) clears bias, feature counter, accumulator and
// all valid flags; weights hold nothing defined until written.
// The pipe stalls, and in_ready drops, only while a finished result sits at the
// lookup stage and the output register still holds an untaken word.
module logistic_regression_inference
  import lri_pkg::*;
#(
  parameter int MAX_FEATURES    = 64,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_op,
  input  logic [5:0]                in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               out_probability,
  output logic signed [ACC_W-1:0]   out_logit,
  output logic                      out_size_error,
  input  logic                      cfg_wr_en,
  input  logic [FC_W-1:0]           cfg_wr_data
);

  logic                      hold;
  logic                      adv;
  logic                      accept;
  lri_tag_t                  a_tag;
  logic signed [VALUE_W-1:0] a_value;
  logic signed [VALUE_W-1:0] a_weight;
  lri_res_t                  c_res;
  logic signed [ACC_W-1:0]   c_sum;

  // Pipeline advance and input handshake.
  assign adv      = !hold;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  lri_front #(
    .MAX_FEATURES(MAX_FEATURES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .accept     (accept),
    .in_op      (in_op),
    .in_index   (in_index),
    .in_value   (in_value),
    .in_last    (in_last),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .a_tag      (a_tag),
    .a_value    (a_value),
    .a_weight   (a_weight)
  );

  lri_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .a_tag   (a_tag),
    .a_value (a_value),
    .a_weight(a_weight),
    .c_res   (c_res),
    .c_sum   (c_sum)
  );

  lri_post #(
    .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
  ) u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .c_res          (c_res),
    .c_sum          (c_sum),
    .out_ready      (out_ready),
    .hold           (hold),
    .out_valid      (out_valid),
    .out_probability(out_probability),
    .out_logit      (out_logit),
    .out_size_error (out_size_error)
  );

endmodule

@@ hdl/lri_checker.sv @@
module lri_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_probability,
  input logic [39:0] out_logit,
  input logic        out_size_error
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_logit) &&
      $stable(out_probability) && $stable(out_size_error))
    else $error("result word changed while stalled");

  // The input side only stalls behind a waiting result word.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A non-negative logit scores at least one half.
  a_prob_hi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_logit[39] |-> out_probability >= 16'h8000)
    else $error("probability below one half for non-negative logit");

  // A negative logit scores at most one half.
  a_prob_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_logit[39] |-> out_probability <= 16'h8000)
    else $error("probability above one half for negative logit");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind logistic_regression_inference lri_checker u_lri_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_probability(out_probability),
  .out_logit      (out_logit),
  .out_size_error (out_size_error)
);

@@ verif/logistic_regression_inference_test.sv @@
`timescale 1ns / 100ps

module logistic_regression_inference_test
  import lri_pkg::*;
();

  localparam int     TABLE_SIZE = 256;
  localparam longint ACC_HI     = 64'sd549755813887;
  localparam longint ACC_LO     = -ACC_HI - 64'sd1;
  localparam longint HALF_SPAN  = 64'sd1 <<< 27;
  localparam longint unsigned ONE_Q32 = 64'd1 << 32;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     CYCLE_LIMIT   = 600000;

  // One expected score.
  typedef struct {
    logic [15:0]        prob;
    logic signed [39:0] logit;
    logic               size_err;
  } score_t;

  // Keeps its own copy of weights, bias and sum, and the scores still owed.
  class logistic_scores;
    logic signed [15:0] weight_mem [64];
    logic signed [15:0] bias_q;
    longint             acc;
    int                 seen;
    int                 count_cfg;
    logic [15:0]        sig_rom [TABLE_SIZE];
    score_t             pending_scores [$];
    int                 errors;
    int                 scored;
    int                 words;

    function new();
      longint unsigned off, mag, e, d, num, r;
      bit neg;
      int k;
      foreach (weight_mem[i]) weight_mem[i] = '0;
      bias_q = '0;
      acc = 0;
      seen = 0;
      count_cfg = FC_RESET;
      errors = 0;
      scored = 0;
      words = 0;
      // Each table entry sits at the midpoint of its bin over [-8, 8).
      for (k = 0; k < TABLE_SIZE; k++) begin
        off = ((64'd2 * k + 64'd1) << 27) / TABLE_SIZE;
        neg = off < (64'd1 << 27);
        mag = neg ? (64'd1 << 27) - off : off - (64'd1 << 27);
        e = exp_neg(mag);
        d = ONE_Q32 + e;
        num = neg ? (e << 16) : (64'd1 << 48);
        r = (num + d / 2) / d;
        sig_rom[k] = (r > 64'd65535) ? 16'hffff : r[15:0];
      end
    endfunction

    // exp(-a) in Q0.32 for a Q8.24 magnitude: series for a/16, then squared four times.
    function longint unsigned exp_neg(longint unsigned a);
      longint unsigned term, e;
      longint sum;
      int i;
      term = ONE_Q32;
      sum = longint'(ONE_Q32);
      for (i = 1; i <= 12; i++) begin
        term = ((term * a) >> 28) / longint'(i);
        if (i % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      e = sum;
      for (i = 0; i < 4; i++) begin
        if (e >= ONE_Q32) begin
          e = ONE_Q32;
        end else begin
          e = (e * e) >> 32;
        end
      end
      return e;
    endfunction

    function longint clip40(longint s);
      if (s > ACC_HI) return ACC_HI;
      if (s < ACC_LO) return ACC_LO;
      return s;
    endfunction

    // Apply one accepted word and queue the score it closes, if any.
    function void take_word(logic [1:0] op, logic [5:0] ix, logic signed [15:0] val,
                            logic last);
      score_t s;
      longint logit, c;
      longint unsigned tix;
      words++;
      case (op)
        OP_WEIGHT: weight_mem[ix] = val;
        OP_BIAS: bias_q = val;
        OP_FEATURE: begin
          acc = clip40(acc + longint'(val) * longint'(weight_mem[ix]));
          if (!last) begin
            if (seen < 127) seen++;
          end else begin
            s.size_err = ((seen + 1) != count_cfg);
            logit = clip40(acc + longint'(bias_q) * 64'sd4096);
            c = logit;
            if (c < -HALF_SPAN) c = -HALF_SPAN;
            if (c > HALF_SPAN - 1) c = HALF_SPAN - 1;
            tix = ((c + HALF_SPAN) * TABLE_SIZE) >> 28;
            if (tix >= TABLE_SIZE) tix = TABLE_SIZE - 1;
            s.prob = sig_rom[tix];
            s.logit = logit[39:0];
            pending_scores.push_back(s);
            acc = 0;
            seen = 0;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one taken result word with the oldest score owed.
    function void match_score(logic [15:0] prob, logic signed [39:0] logit, logic size_err);
      score_t s;
      if (pending_scores.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: prob %0d logit %0d err %0d", prob, logit, size_err);
        end
        return;
      end
      s = pending_scores.pop_front();
      scored++;
      if (s.prob !== prob || s.logit !== logit || s.size_err !== size_err) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp prob %0d logit %0d err %0d, got prob %0d logit %0d err %0d",
                   s.prob, s.logit, s.size_err, prob, logit, size_err);
        end
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_op = '0;
  logic [5:0]                in_index = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      in_last = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [15:0]               out_probability;
  logic signed [ACC_W-1:0]   out_logit;
  logic                      out_size_error;
  logic                      cfg_wr_en = 1'b0;
  logic [FC_W-1:0]           cfg_wr_data = '0;

  logistic_scores ledger;
  bit  written [64];
  int  fc_now = FC_RESET;
  int  send_idle = 0;
  int  recv_idle = 0;
  int  n_settings = 0;
  int  cycles = 0;

  logistic_regression_inference uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_probability (out_probability),
    .out_logit       (out_logit),
    .out_size_error  (out_size_error),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check each taken word, then decide whether to stall next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      ledger.match_score(out_probability, out_logit, out_size_error);
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Offer one input word, with random idle cycles first, and wait until it is taken.
  task automatic send_word(lri_op_t op, logic [5:0] ix, logic signed [15:0] val, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_index <= ix;
    in_value <= val;
    in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.take_word(op, ix, val, last);
  endtask

  task automatic put_weight(logic [5:0] ix, logic signed [15:0] val);
    written[ix] = 1'b1;
    send_word(OP_WEIGHT, ix, val, 1'($urandom_range(1)));
  endtask

  // Hold off the sender until every owed score is back and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(int n);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n[FC_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.count_cfg = n;
    fc_now = n;
    n_settings++;
  endtask

  // Mix of extremes, small values within plus or minus one and full-range values.
  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3, 4, 5: return 16'($urandom_range(8191)) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  // One long sample on a single slot to drive the sum into a limit.
  task automatic overflow_sample(logic signed [15:0] w, logic signed [15:0] f, int len);
    int k;
    put_weight(6'd7, w);
    for (k = 0; k < len; k++) begin
      send_word(OP_FEATURE, 6'd7, f, k == len - 1);
    end
  endtask

  // Random samples: mostly the configured length, some broken, with writes mixed in.
  task automatic run_phase(int budget);
    int sent, len, k, roll, tries;
    logic [5:0] ix;
    sent = 0;
    repeat (4) begin
      put_weight(6'($urandom_range(63)), rand_value());
      sent++;
    end
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        len = (fc_now == 0) ? $urandom_range(1, 3) : fc_now;
      end else if (roll < 99 || fc_now < 64) begin
        len = $urandom_range(1, fc_now + 3);
      end else begin
        len = $urandom_range(128, 136);
      end
      for (k = 0; k < len; k++) begin
        // Occasional write or unused word between features.
        if ($urandom_range(99) < 8) begin
          case ($urandom_range(3))
            0, 1: put_weight(6'($urandom_range(63)), rand_value());
            2: send_word(OP_BIAS, 6'($urandom), rand_value(), 1'($urandom_range(1)));
            default: send_word(OP_SPARE, 6'($urandom), 16'($urandom),
                               1'($urandom_range(1)));
          endcase
          sent++;
        end
        // Only slots already written are read.
        ix = (roll < 75) ? k[5:0] : 6'($urandom_range(63));
        tries = 0;
        while (!written[ix] && tries < 200) begin
          ix = 6'($urandom_range(63));
          tries++;
        end
        if (!written[ix]) ix = 6'd0;
        send_word(OP_FEATURE, ix, rand_value(), k == len - 1);
        sent++;
      end
      if ($urandom_range(29) == 0) settle();
    end
  endtask

  initial begin
    ledger = new();
    send_idle = 20;
    recv_idle = 68;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset count: extremes, unused op, writes inside a sample.
    put_weight(6'd0, 16'sh7fff);
    put_weight(6'd63, 16'sh8000);
    put_weight(6'd1, 16'sh1000);
    send_word(OP_BIAS, 6'd0, 16'sh1000, 1'b1);
    send_word(OP_SPARE, 6'd63, 16'shffff, 1'b1);
    send_word(OP_FEATURE, 6'd0, 16'sh8000, 1'b0);
    send_word(OP_FEATURE, 6'd63, 16'sh7fff, 1'b0);
    send_word(OP_FEATURE, 6'd1, 16'sh0000, 1'b1);
    // Weight written right before the feature that reads it.
    put_weight(6'd5, 16'shf000);
    send_word(OP_FEATURE, 6'd5, 16'sh7fff, 1'b1);
    send_word(OP_BIAS, 6'd0, 16'sh8000, 1'b0);
    send_word(OP_FEATURE, 6'd0, 16'sh7fff, 1'b1);
    // Bias changed in the middle of a sample applies at its end.
    send_word(OP_FEATURE, 6'd63, 16'sh7fff, 1'b0);
    send_word(OP_BIAS, 6'd42, 16'sh7fff, 1'b0);
    send_word(OP_FEATURE, 6'd63, 16'shffff, 1'b1);
    // Sums at and right around zero.
    send_word(OP_BIAS, 6'd0, 16'sh0000, 1'b0);
    send_word(OP_FEATURE, 6'd1, 16'sh0000, 1'b1);
    send_word(OP_FEATURE, 6'd1, 16'sh0001, 1'b1);
    send_word(OP_FEATURE, 6'd1, 16'shffff, 1'b1);
    run_phase(60);

    set_count(3);
    run_phase(60);
    set_count(1);
    run_phase(40);

    send_idle = 68;
    recv_idle = 20;
    set_count(0);
    run_phase(30);
    set_count(127);
    // Both accumulator limits, with a bias that pushes further past each one.
    send_word(OP_BIAS, 6'd0, 16'sh7fff, 1'b0);
    overflow_sample(16'sh8000, 16'sh8000, 513);
    send_word(OP_BIAS, 6'd0, 16'sh8000, 1'b0);
    overflow_sample(16'sh8000, 16'sh7fff, 513);
    set_count(5);
    run_phase(40);

    send_idle = 0;
    recv_idle = 0;
    set_count(64);
    run_phase(30);
    set_count(2);
    run_phase(40);
    set_count($urandom_range(6, 20));
    run_phase(40);

    settle();
    $display("summary: %0d words taken, %0d scores checked over %0d count settings",
             ledger.words, ledger.scored, n_settings + 1);
    $display("summary: right and wrong sample lengths, mid-sample writes, unused ops, sum limits");
    if (ledger.errors == 0 && ledger.pending_scores.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
